FILE: sv/hslrgb_pkg.sv
// ----------------------------------------------------------------------------
// hslrgb_pkg
// Shared field widths, range limits, divide-by-constant reciprocals and
// hue sector codes for the HSL to RGB converter.
// ----------------------------------------------------------------------------
package hslrgb_pkg;

   // field widths
   localparam int unsigned HUE_W = 9;
   localparam int unsigned PCT_W = 7;
   localparam int unsigned CH_W  = 8;

   // range limits
   localparam int unsigned HUE_RANGE = 360;
   localparam int unsigned PCT_MAX   = 100;
   localparam int unsigned CH_MAX    = 255;

   // cycles from an accepted request to its response strobe
   localparam int unsigned PIPE_LATENCY = 9;

   // exact floor(x/100) for x < 2**15: (x * recip) >> shift
   localparam int unsigned DIV100_IN_W   = 15;
   localparam int unsigned DIV100_SHIFT  = 22;
   localparam int unsigned DIV100_RECIP  = ((2 ** DIV100_SHIFT) + PCT_MAX - 1) / PCT_MAX;
   localparam int unsigned DIV100_PROD_W = DIV100_IN_W + 16;

   // exact floor(x/360) for x < 2**17: (x * recip) >> shift
   localparam int unsigned DIV360_IN_W   = 17;
   localparam int unsigned DIV360_SHIFT  = 26;
   localparam int unsigned DIV360_RECIP  =
      ((2 ** DIV360_SHIFT) + HUE_RANGE - 1) / HUE_RANGE;
   localparam int unsigned DIV360_PROD_W = DIV360_IN_W + 18;

   // piecewise-linear sector of a channel hue
   typedef enum logic [1:0] {
      SEC_RISE,
      SEC_TOP,
      SEC_FALL,
      SEC_BASE
   } sector_type;

endpackage

FILE: sv/hsl_to_rgb_converter_core.sv
// pipeline: the datapath stages, the channel stages and the response registers,
//   with a valid bit that travels alongside the data
// throughput: one colour per clock cycle, set by the fully pipelined datapath
// reset: synchronous, clears the valid bits of every stage; busy is high
//   only while reset is applied
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_core
// HSL to RGB colour conversion: hue in degrees, saturation and lightness in
// percent in; 8-bit red, green and blue out, one response per request.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_core #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [hslrgb_pkg::HUE_W-1:0]   req_hue_deg,
   input  logic [hslrgb_pkg::PCT_W-1:0]   req_sat_pct,
   input  logic [hslrgb_pkg::PCT_W-1:0]   req_light_pct,
   output logic                           rsp_valid,
   output logic [hslrgb_pkg::CH_W-1:0]    rsp_red,
   output logic [hslrgb_pkg::CH_W-1:0]    rsp_green,
   output logic [hslrgb_pkg::CH_W-1:0]    rsp_blue
);
   import hslrgb_pkg::*;

   localparam int unsigned FX_W = FRAC_BITS + 1;
   localparam int unsigned LV_W = FRAC_BITS + 2;
   localparam int unsigned PR_W = FX_W + LV_W;

   localparam logic [FX_W-1:0]  ONE_FX   = FX_W'(1) << FRAC_BITS;
   localparam logic [FX_W-1:0]  HALF_FX  = ONE_FX >> 1;
   localparam logic [FX_W-1:0]  THIRD_FX = FX_W'((2 ** FRAC_BITS) / 3);
   localparam logic [FX_W-1:0]  Q100_FX  = FX_W'((2 ** FRAC_BITS) / PCT_MAX);
   localparam logic [PCT_W-1:0] R100     = PCT_W'((2 ** FRAC_BITS) % PCT_MAX);
   localparam logic [FX_W-1:0]  Q360_FX  = FX_W'((2 ** FRAC_BITS) / HUE_RANGE);
   localparam logic [HUE_W-1:0] R360     = HUE_W'((2 ** FRAC_BITS) % HUE_RANGE);

   logic                      accept;
   logic [PIPE_LATENCY-1:0]   vld_ff;
   logic [PIPE_LATENCY-1:0]   vld_in;

   logic [HUE_W-1:0]          hue_c;
   logic [PCT_W-1:0]          sat_c;
   logic [PCT_W-1:0]          light_c;

   // stage 1
   logic [FX_W-1:0]           lq1_ff, sq1_ff, hq1_ff;
   logic [DIV100_IN_W-1:0]    lr1_ff, sr1_ff, gp1_ff;
   logic [DIV360_IN_W-1:0]    hr1_ff;
   logic                      grey1_ff;

   // stage 2
   logic [DIV100_PROD_W-1:0]  lfix_prod, sfix_prod, gy_prod;
   logic [DIV360_PROD_W-1:0]  hfix_prod;
   logic [FX_W-1:0]           lq2_ff, sq2_ff, hq2_ff;
   logic [PCT_W-1:0]          lfix2_ff, sfix2_ff;
   logic [HUE_W-1:0]          hfix2_ff;
   logic [CH_W-1:0]           gy2_ff;
   logic                      grey2_ff;

   // stage 3
   logic [FX_W-1:0]           l3_ff, s3_ff, h3_ff;
   logic [CH_W-1:0]           gy3_ff;
   logic                      grey3_ff;

   // stage 4
   logic                      low_in;
   logic [LV_W-1:0]           opb_in;
   logic [PR_W-1:0]           prod4_ff;
   logic                      low4_ff;
   logic [FX_W-1:0]           l4_ff, s4_ff, h4_ff;
   logic [CH_W-1:0]           gy4_ff;
   logic                      grey4_ff;

   // stage 5
   logic [LV_W-1:0]           prod_hi;
   logic [LV_W-1:0]           q_in;
   logic [LV_W-1:0]           q5_ff;
   logic [FX_W-1:0]           l5_ff, h5_ff;
   logic [CH_W-1:0]           gy5_ff;
   logic                      grey5_ff;

   // stage 6
   logic [LV_W-1:0]           two_l;
   logic [LV_W-1:0]           p_in;
   logic [LV_W-1:0]           tr_sum;
   logic [FX_W-1:0]           tr_in;
   logic [FX_W-1:0]           tb_in;
   logic [LV_W-1:0]           q6_ff, p6_ff, d6_ff;
   logic [FX_W-1:0]           tr6_ff, tg6_ff, tb6_ff;
   logic [CH_W-1:0]           gy6_ff, gy7_ff, gy8_ff;
   logic                      grey6_ff, grey7_ff, grey8_ff;

   // channel levels and output registers
   logic [CH_W-1:0]           lvl_r, lvl_g, lvl_b;
   logic [CH_W-1:0]           red_ff, green_ff, blue_ff;

   // request transfer
   assign busy   = reset;
   assign accept = start && !busy;

   // valid bits travel alongside the data
   assign vld_in = {vld_ff[PIPE_LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // range reduction of the request fields
   always_comb begin
      hue_c   = (req_hue_deg >= HUE_W'(HUE_RANGE)) ?
                req_hue_deg - HUE_W'(HUE_RANGE) : req_hue_deg;
      sat_c   = (req_sat_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : req_sat_pct;
      light_c = (req_light_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : req_light_pct;
   end

   // stage 1: quotient and remainder parts of the fixed-point scaling
   always_ff @(posedge clock) begin
      lq1_ff   <= FX_W'(light_c) * Q100_FX;
      sq1_ff   <= FX_W'(sat_c) * Q100_FX;
      hq1_ff   <= FX_W'(hue_c) * Q360_FX;
      lr1_ff   <= DIV100_IN_W'(light_c) * DIV100_IN_W'(R100);
      sr1_ff   <= DIV100_IN_W'(sat_c) * DIV100_IN_W'(R100);
      hr1_ff   <= DIV360_IN_W'(hue_c) * DIV360_IN_W'(R360);
      gp1_ff   <= DIV100_IN_W'(light_c) * DIV100_IN_W'(CH_MAX);
      grey1_ff <= (sat_c == '0);
   end

   // stage 2: small divisions by reciprocal multiplication
   always_comb begin
      lfix_prod = DIV100_PROD_W'(lr1_ff) * DIV100_PROD_W'(DIV100_RECIP);
      sfix_prod = DIV100_PROD_W'(sr1_ff) * DIV100_PROD_W'(DIV100_RECIP);
      gy_prod   = DIV100_PROD_W'(gp1_ff) * DIV100_PROD_W'(DIV100_RECIP);
      hfix_prod = DIV360_PROD_W'(hr1_ff) * DIV360_PROD_W'(DIV360_RECIP);
   end

   always_ff @(posedge clock) begin
      lq2_ff   <= lq1_ff;
      sq2_ff   <= sq1_ff;
      hq2_ff   <= hq1_ff;
      lfix2_ff <= PCT_W'(lfix_prod >> DIV100_SHIFT);
      sfix2_ff <= PCT_W'(sfix_prod >> DIV100_SHIFT);
      hfix2_ff <= HUE_W'(hfix_prod >> DIV360_SHIFT);
      gy2_ff   <= CH_W'(gy_prod >> DIV100_SHIFT);
      grey2_ff <= grey1_ff;
   end

   // stage 3: lightness, saturation and hue as fractions
   always_ff @(posedge clock) begin
      l3_ff    <= lq2_ff + FX_W'(lfix2_ff);
      s3_ff    <= sq2_ff + FX_W'(sfix2_ff);
      h3_ff    <= hq2_ff + FX_W'(hfix2_ff);
      gy3_ff   <= gy2_ff;
      grey3_ff <= grey2_ff;
   end

   // stage 4: product for the upper interpolation point
   always_comb begin
      low_in = (l3_ff < HALF_FX);
      opb_in = low_in ? LV_W'(ONE_FX) + LV_W'(s3_ff) : LV_W'(s3_ff);
   end

   always_ff @(posedge clock) begin
      prod4_ff <= PR_W'(l3_ff) * PR_W'(opb_in);
      low4_ff  <= low_in;
      l4_ff    <= l3_ff;
      s4_ff    <= s3_ff;
      h4_ff    <= h3_ff;
      gy4_ff   <= gy3_ff;
      grey4_ff <= grey3_ff;
   end

   // stage 5: upper interpolation point q
   always_comb begin
      prod_hi = LV_W'(prod4_ff >> FRAC_BITS);
      q_in    = low4_ff ? prod_hi : LV_W'(l4_ff) + LV_W'(s4_ff) - prod_hi;
   end

   always_ff @(posedge clock) begin
      q5_ff    <= q_in;
      l5_ff    <= l4_ff;
      h5_ff    <= h4_ff;
      gy5_ff   <= gy4_ff;
      grey5_ff <= grey4_ff;
   end

   // stage 6: lower point p, span, and per-channel hue with wrap
   always_comb begin
      two_l  = {l5_ff, 1'b0};
      p_in   = (two_l > q5_ff) ? two_l - q5_ff : '0;
      tr_sum = LV_W'(h5_ff) + LV_W'(THIRD_FX);
      tr_in  = (tr_sum > LV_W'(ONE_FX)) ? FX_W'(tr_sum - LV_W'(ONE_FX)) : FX_W'(tr_sum);
      tb_in  = (h5_ff >= THIRD_FX) ? h5_ff - THIRD_FX : h5_ff + ONE_FX - THIRD_FX;
   end

   always_ff @(posedge clock) begin
      q6_ff    <= q5_ff;
      p6_ff    <= p_in;
      d6_ff    <= q5_ff - p_in;
      tr6_ff   <= tr_in;
      tg6_ff   <= h5_ff;
      tb6_ff   <= tb_in;
      gy6_ff   <= gy5_ff;
      grey6_ff <= grey5_ff;
   end

   // per-channel sector rule
   hslrgb_channel #(.FRAC_BITS(FRAC_BITS)) u_chan_red (
      .clock (clock),
      .lvl_q (q6_ff),
      .lvl_p (p6_ff),
      .lvl_d (d6_ff),
      .hue_t (tr6_ff),
      .level (lvl_r)
   );

   hslrgb_channel #(.FRAC_BITS(FRAC_BITS)) u_chan_green (
      .clock (clock),
      .lvl_q (q6_ff),
      .lvl_p (p6_ff),
      .lvl_d (d6_ff),
      .hue_t (tg6_ff),
      .level (lvl_g)
   );

   hslrgb_channel #(.FRAC_BITS(FRAC_BITS)) u_chan_blue (
      .clock (clock),
      .lvl_q (q6_ff),
      .lvl_p (p6_ff),
      .lvl_d (d6_ff),
      .hue_t (tb6_ff),
      .level (lvl_b)
   );

   // grey level kept in step with the channel stages
   always_ff @(posedge clock) begin
      gy7_ff   <= gy6_ff;
      gy8_ff   <= gy7_ff;
      grey7_ff <= grey6_ff;
      grey8_ff <= grey7_ff;
   end

   // response registers: grey for zero saturation
   always_ff @(posedge clock) begin
      red_ff   <= grey8_ff ? gy8_ff : lvl_r;
      green_ff <= grey8_ff ? gy8_ff : lvl_g;
      blue_ff  <= grey8_ff ? gy8_ff : lvl_b;
   end

   assign rsp_valid = vld_ff[PIPE_LATENCY-1];
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

FILE: sv/hslrgb_channel.sv
// ----------------------------------------------------------------------------
// hslrgb_channel
// One colour channel: classifies the channel hue into its sector, forms the
// interpolated level between p and q and scales it to an 8-bit intensity.
// Two register stages; the scaled level is presented combinationally.
// ----------------------------------------------------------------------------
module hslrgb_channel #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic [FRAC_BITS+1:0]          lvl_q,
   input  logic [FRAC_BITS+1:0]          lvl_p,
   input  logic [FRAC_BITS+1:0]          lvl_d,
   input  logic [FRAC_BITS:0]            hue_t,
   output logic [hslrgb_pkg::CH_W-1:0]   level
);
   import hslrgb_pkg::*;

   localparam int unsigned FX_W = FRAC_BITS + 1;
   localparam int unsigned LV_W = FRAC_BITS + 2;
   localparam int unsigned T6_W = FRAC_BITS + 4;
   localparam int unsigned PR_W = LV_W + FX_W;
   localparam int unsigned C_W  = FRAC_BITS + 3;
   localparam int unsigned S_W  = C_W + CH_W;
   localparam int unsigned W_W  = S_W - FRAC_BITS;

   localparam logic [FX_W-1:0] ONE_FX        = FX_W'(1) << FRAC_BITS;
   localparam logic [FX_W-1:0] TWO_THIRDS_FX = FX_W'((2 * (2 ** FRAC_BITS)) / 3);
   localparam logic [T6_W-1:0] ONE_T6        = T6_W'(ONE_FX);

   logic [T6_W-1:0] t2;
   logic [T6_W-1:0] t3;
   logic [T6_W-1:0] t6;
   logic [FX_W-1:0] fall_gap;
   logic [T6_W-1:0] fall6;
   sector_type      sec_in;
   logic [FX_W-1:0] fac_in;

   sector_type      sec_a_ff;
   logic [FX_W-1:0] fac_a_ff;
   logic [LV_W-1:0] d_a_ff;
   logic [LV_W-1:0] p_a_ff;
   logic [LV_W-1:0] q_a_ff;

   sector_type      sec_b_ff;
   logic [PR_W-1:0] prod_b_ff;
   logic [LV_W-1:0] p_b_ff;
   logic [LV_W-1:0] q_b_ff;

   logic [C_W-1:0]  slope_add;
   logic [C_W-1:0]  lvl_c;
   logic [S_W-1:0]  scaled;
   logic [W_W-1:0]  whole;

   // sector classification and slope factor
   always_comb begin
      t2       = T6_W'(hue_t) << 1;
      t3       = t2 + T6_W'(hue_t);
      t6       = t3 << 1;
      fall_gap = TWO_THIRDS_FX - hue_t;
      fall6    = (T6_W'(fall_gap) << 2) + (T6_W'(fall_gap) << 1);
      if (t6 < ONE_T6) begin
         sec_in = SEC_RISE;
         fac_in = FX_W'(t6);
      end else if (t2 < ONE_T6) begin
         sec_in = SEC_TOP;
         fac_in = '0;
      end else if (t3 < (ONE_T6 << 1)) begin
         sec_in = SEC_FALL;
         fac_in = FX_W'(fall6);
      end else begin
         sec_in = SEC_BASE;
         fac_in = '0;
      end
   end

   // stage a: sector and factor
   always_ff @(posedge clock) begin
      sec_a_ff <= sec_in;
      fac_a_ff <= fac_in;
      d_a_ff   <= lvl_d;
      p_a_ff   <= lvl_p;
      q_a_ff   <= lvl_q;
   end

   // stage b: slope product
   always_ff @(posedge clock) begin
      sec_b_ff  <= sec_a_ff;
      prod_b_ff <= PR_W'(d_a_ff) * PR_W'(fac_a_ff);
      p_b_ff    <= p_a_ff;
      q_b_ff    <= q_a_ff;
   end

   // level select, scale by 255 and clamp
   always_comb begin
      slope_add = C_W'(prod_b_ff >> FRAC_BITS);
      case (sec_b_ff) inside
         SEC_RISE, SEC_FALL: lvl_c = C_W'(p_b_ff) + slope_add;
         SEC_TOP:            lvl_c = C_W'(q_b_ff);
         default:            lvl_c = C_W'(p_b_ff);
      endcase
      scaled = (S_W'(lvl_c) << CH_W) - S_W'(lvl_c);
      whole  = scaled[S_W-1:FRAC_BITS];
      level  = (whole > W_W'(CH_MAX)) ? CH_W'(CH_MAX) : whole[CH_W-1:0];
   end

endmodule

FILE: sv/hslrgb_checker.sv
// ----------------------------------------------------------------------------
// hslrgb_checker
// Port-level checks of the HSL to RGB converter: fixed response latency and
// a few colour identities that hold for any fixed-point precision.
// ----------------------------------------------------------------------------
module hslrgb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [hslrgb_pkg::HUE_W-1:0]  req_hue_deg,
   input logic [hslrgb_pkg::PCT_W-1:0]  req_sat_pct,
   input logic [hslrgb_pkg::PCT_W-1:0]  req_light_pct,
   input logic                          rsp_valid,
   input logic [hslrgb_pkg::CH_W-1:0]   rsp_red,
   input logic [hslrgb_pkg::CH_W-1:0]   rsp_green,
   input logic [hslrgb_pkg::CH_W-1:0]   rsp_blue
);
   import hslrgb_pkg::*;

   logic accept;

   assign accept = start && !busy;

   // every request transfer gives a response after the fixed latency
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_LATENCY rsp_valid)
      else $error("response missing after request transfer");

   // no response without a matching request
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, PIPE_LATENCY))
      else $error("response without request transfer");

   // zero saturation gives a grey
   a_grey_on_zero_sat: assert property (@(posedge clock) disable iff (reset)
      (accept && req_sat_pct == '0) |-> ##PIPE_LATENCY
      (rsp_red == rsp_green && rsp_green == rsp_blue))
      else $error("zero saturation did not give a grey");

   // full lightness gives white
   a_white_on_full_light: assert property (@(posedge clock) disable iff (reset)
      (accept && req_light_pct >= PCT_W'(PCT_MAX)) |-> ##PIPE_LATENCY
      (rsp_red == CH_W'(CH_MAX) && rsp_green == CH_W'(CH_MAX) &&
       rsp_blue == CH_W'(CH_MAX)))
      else $error("full lightness did not give white");

   // hue zero: red dominant, green and blue equal
   a_red_hue: assert property (@(posedge clock) disable iff (reset)
      (accept && req_hue_deg == '0 && req_sat_pct != '0) |-> ##PIPE_LATENCY
      (rsp_green == rsp_blue && rsp_red >= rsp_green))
      else $error("hue zero did not give a red-dominant colour");

endmodule

bind hsl_to_rgb_converter_core hslrgb_checker u_hslrgb_checker (.*);
